[sv/sbf_pkg.sv]
`timescale 1ns / 1ps
package sbf_pkg;

    // Batch sizing
    localparam int BATCH_DEPTH = 64;
    localparam int IDX_W       = $clog2(BATCH_DEPTH);
    localparam int CNT_W       = $clog2(BATCH_DEPTH + 1);

    // Field widths
    localparam int NONCE_W  = 32;
    localparam int GAS_W    = 32;
    localparam int ACC_W    = 38;
    localparam int HASH_W   = 64;
    localparam int ENTRY_W  = 7;
    localparam int STATUS_W = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Hash constants
    localparam logic [HASH_W-1:0] KEY_MASK   = 64'h0953_4679_5411_4363;
    localparam logic [HASH_W-1:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]        PRIME_LOW  = 9'h1B3;
    localparam int                PRIME_SHIFT = 40;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Input command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_PUSH_FULL,
        OP_EVAL,
        OP_EVAL_EMPTY
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [NONCE_W-1:0] nonce;
        logic [GAS_W-1:0]   gas;
        logic [CNT_W-1:0]   count;   // entries stored after this command
    } t_queue_entry;

    // x * 0x100000001B3 mod 2^64 = (x << 40) + x * 0x1B3
    function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] x);
        logic [HASH_W-1:0] lo;
        lo = x * {{(HASH_W-9){1'b0}}, PRIME_LOW};
        return (x << PRIME_SHIFT) + lo;
    endfunction

endpackage

[sv/sbf_front.sv]
`timescale 1ns / 1ps
module sbf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [sbf_pkg::NONCE_W-1:0] i_nonce,
    input  logic [sbf_pkg::GAS_W-1:0]   i_tx_gas,
    output logic                        o_q_valid,
    output sbf_pkg::t_queue_entry       o_q_entry,
    input  logic                        i_q_pop
);
    import sbf_pkg::*;

    t_queue_entry      r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_q_count;
    logic [CNT_W-1:0]  r_count;      // shadow of the stored count

    t_queue_entry      w_entry;
    logic              w_push;

    assign o_in_stall = (r_q_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_q_count != '0);
    assign o_q_entry  = r_q[r_rd_ptr];

    // Classify against the count as it stands after all earlier commands.
    always_comb begin
        w_entry.nonce = i_nonce;
        w_entry.gas   = i_tx_gas;
        w_entry.count = r_count;
        if (i_cmd == CMD_PUSH) begin
            if (r_count == CNT_W'(BATCH_DEPTH)) begin
                w_entry.op = OP_PUSH_FULL;
            end else begin
                w_entry.op    = OP_PUSH;
                w_entry.count = r_count + CNT_W'(1);
            end
        end else begin
            w_entry.op = (r_count == '0) ? OP_EVAL_EMPTY : OP_EVAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
            r_count   <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wr_ptr] <= w_entry;
                r_count       <= w_entry.count;
                r_wr_ptr      <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + QPTR_W'(1);
            end
            case ({w_push, i_q_pop})
                2'b10:   r_q_count <= r_q_count + QCNT_W'(1);
                2'b01:   r_q_count <= r_q_count - QCNT_W'(1);
                default: r_q_count <= r_q_count;
            endcase
        end
    end

endmodule

[sv/sbf_back.sv]
`timescale 1ns / 1ps
module sbf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  sbf_pkg::t_queue_entry        i_q_entry,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sbf_pkg::STATUS_W-1:0] o_status,
    output logic [sbf_pkg::HASH_W-1:0]   o_root_hash,
    output logic [sbf_pkg::ACC_W-1:0]    o_total_gas,
    output logic [sbf_pkg::ENTRY_W-1:0]  o_entry_count
);
    import sbf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_GET_V,
        S_CMP,
        S_PLACE,
        S_FOLD_KEY,
        S_FOLD_MIX,
        S_DONE
    } t_state;

    t_state               r_state;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [CNT_W-1:0]     r_out_count;
    logic [ACC_W-1:0]     r_gas;
    logic [HASH_W-1:0]    r_last_root;
    logic [ACC_W-1:0]     r_last_total;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_i;
    logic [CNT_W-1:0]     r_j;
    logic [NONCE_W-1:0]   r_v;
    logic [HASH_W-1:0]    r_key;
    logic [HASH_W-1:0]    r_h;

    logic [NONCE_W-1:0]   mem [BATCH_DEPTH];
    logic [NONCE_W-1:0]   r_rd_data;

    logic                 w_out_free;
    logic                 w_load;        // result register takes a new result
    logic [CNT_W-1:0]     w_rd_idx;
    logic                 w_wr_en;
    logic [CNT_W-1:0]     w_wr_idx;
    logic [NONCE_W-1:0]   w_wr_data;
    logic                 w_shift;       // stored entry above v moves up
    logic                 w_i_more;      // r_i + 1 < r_n
    logic [CNT_W-1:0]     w_i_next;
    logic [ACC_W:0]       w_gas_sum;
    logic [ACC_W-1:0]     w_gas_sat;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_shift    = (r_rd_data > r_v);
    assign w_i_next   = r_i + CNT_W'(1);
    assign w_i_more   = (w_i_next < r_n);
    assign w_gas_sum  = {1'b0, r_gas} + (ACC_W + 1)'(i_q_entry.gas);
    assign w_gas_sat  = w_gas_sum[ACC_W] ? '1 : w_gas_sum[ACC_W-1:0];
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid && w_out_free;
    assign w_load     = (o_q_pop && (i_q_entry.op != OP_EVAL)) ||
                        ((r_state == S_DONE) && w_out_free);

    // Store port control
    always_comb begin
        w_rd_idx  = '0;
        w_wr_en   = 1'b0;
        w_wr_idx  = r_j;
        w_wr_data = r_rd_data;
        case (r_state)
            S_IDLE: begin
                w_wr_en   = o_q_pop && (i_q_entry.op == OP_PUSH);
                w_wr_idx  = i_q_entry.count - CNT_W'(1);
                w_wr_data = i_q_entry.nonce;
            end
            S_START:  w_rd_idx = (r_n == CNT_W'(1)) ? '0 : CNT_W'(1);
            S_GET_V:  w_rd_idx = r_j - CNT_W'(1);
            S_CMP: begin
                w_wr_en  = w_shift;
                w_rd_idx = r_j - CNT_W'(2);
            end
            S_PLACE: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_v;
                w_rd_idx  = w_i_more ? w_i_next : '0;
            end
            S_FOLD_MIX: w_rd_idx = w_i_next;
            default:    w_rd_idx = '0;
        endcase
    end

    // Write-first: reading the address being written returns the new data
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_idx[IDX_W-1:0]] <= w_wr_data;
        end
        r_rd_data <= (w_wr_en && (w_wr_idx[IDX_W-1:0] == w_rd_idx[IDX_W-1:0])) ?
                     w_wr_data : mem[w_rd_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_gas        <= '0;
            r_last_root  <= '0;
            r_last_total <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_out_count <= i_q_entry.count;
                        case (i_q_entry.op)
                            OP_PUSH: begin
                                r_gas        <= w_gas_sat;
                                r_out_status <= ST_OK;
                            end
                            OP_PUSH_FULL: begin
                                r_out_status <= ST_FULL;
                            end
                            OP_EVAL_EMPTY: begin
                                r_out_status <= ST_EMPTY;
                            end
                            OP_EVAL: begin
                                r_n     <= i_q_entry.count;
                                r_state <= S_START;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_START: begin
                    r_h <= FNV_BASIS;
                    if (r_n == CNT_W'(1)) begin
                        r_i     <= '0;
                        r_state <= S_FOLD_KEY;
                    end else begin
                        r_i     <= CNT_W'(1);
                        r_j     <= CNT_W'(1);
                        r_state <= S_GET_V;
                    end
                end
                S_GET_V: begin
                    r_v     <= r_rd_data;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_shift) begin
                        r_j <= r_j - CNT_W'(1);
                        if (r_j == CNT_W'(1)) begin
                            r_state <= S_PLACE;
                        end
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    if (w_i_more) begin
                        r_i     <= w_i_next;
                        r_j     <= w_i_next;
                        r_state <= S_GET_V;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_FOLD_KEY;
                    end
                end
                S_FOLD_KEY: begin
                    r_key   <= KEY_MASK ^ mul_prime(HASH_W'(r_rd_data));
                    r_state <= S_FOLD_MIX;
                end
                S_FOLD_MIX: begin
                    r_h <= mul_prime(r_h ^ r_key);
                    if (w_i_more) begin
                        r_i     <= w_i_next;
                        r_state <= S_FOLD_KEY;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_last_root  <= r_h;
                        r_last_total <= r_gas;
                        r_out_status <= ST_OK;
                        r_out_count  <= r_n;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Kept root and total only change when a new result is loaded,
    // so they serve directly as the result payload.
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_root_hash   = r_last_root;
    assign o_total_gas   = r_last_total;
    assign o_entry_count = ENTRY_W'(r_out_count);

endmodule

[sv/sorted_batch_fnv_fold_hash.sv]
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// input    | i_in_valid / o_in_stall    | i_cmd, i_nonce, i_tx_gas
// result   | o_out_valid / i_out_stall  | o_status, o_root_hash, o_total_gas,
//          |                            | o_entry_count
//
// Push, full push and empty evaluate: queued at the accepting edge, then popped by
// the back, once it is idle and the result register is free, and loaded into the
// result register at the popping edge.
// Evaluate of n entries: a start step, insertion sort over the single-port-read
// store (read v, compare and shift each larger entry up, place v) for each entry
// after the first, then the fold per entry (key multiply, then mix multiply), then
// a done step that loads the result register once it is free.
// Reset (synchronous, active low) clears control, counts, gas and the kept
// root; the nonce store needs no clearing pass.
// The two-entry queue lets the input side keep accepting while the back is
// busy; the result register holds under i_out_stall and the back waits on it.
module sorted_batch_fnv_fold_hash (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [sbf_pkg::NONCE_W-1:0]  i_nonce,
    input  logic [sbf_pkg::GAS_W-1:0]    i_tx_gas,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sbf_pkg::STATUS_W-1:0] o_status,
    output logic [sbf_pkg::HASH_W-1:0]   o_root_hash,
    output logic [sbf_pkg::ACC_W-1:0]    o_total_gas,
    output logic [sbf_pkg::ENTRY_W-1:0]  o_entry_count
);
    import sbf_pkg::*;

    // Front to back: classified transaction, queued
    logic         w_q_valid;
    t_queue_entry w_q_entry;
    logic         w_q_pop;

    // Front: takes transactions, tracks the stored count and classifies
    // each command as push, refused push, evaluate or empty evaluate.
    sbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_nonce    (i_nonce),
        .i_tx_gas   (i_tx_gas),
        .o_q_valid  (w_q_valid),
        .o_q_entry  (w_q_entry),
        .i_q_pop    (w_q_pop)
    );

    // Back: owns the nonce store and gas total, runs sort and fold,
    // and holds the result register.
    sbf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_entry     (w_q_entry),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_root_hash   (o_root_hash),
        .o_total_gas   (o_total_gas),
        .o_entry_count (o_entry_count)
    );

endmodule

[sv/sbf_checker.sv]
`timescale 1ns / 1ps
module sbf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_cmd,
    input logic [sbf_pkg::NONCE_W-1:0]  i_nonce,
    input logic [sbf_pkg::GAS_W-1:0]    i_tx_gas,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [sbf_pkg::STATUS_W-1:0] o_status,
    input logic [sbf_pkg::HASH_W-1:0]   o_root_hash,
    input logic [sbf_pkg::ACC_W-1:0]    o_total_gas,
    input logic [sbf_pkg::ENTRY_W-1:0]  o_entry_count
);
    import sbf_pkg::*;

    // Offered transaction stays put while stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_cmd) &&
            $stable(i_nonce) && $stable(i_tx_gas))
        else $error("input changed under stall");

    // Held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
            $stable(o_root_hash) && $stable(o_total_gas) && $stable(o_entry_count))
        else $error("result changed under stall");

    // Refused push only when the batch is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_entry_count == ENTRY_W'(BATCH_DEPTH))
        else $error("full status with batch not full");

    // Empty batch was never evaluated, so kept values are still zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |->
            (o_entry_count == '0) && (o_root_hash == '0) && (o_total_gas == '0))
        else $error("empty status with stored entries or kept values");

    // Count steps by at most one from a taken result to a full-status result right behind it
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid && (o_status == ST_FULL) |->
            $past(o_entry_count) == o_entry_count ||
            $past(o_entry_count) == o_entry_count - ENTRY_W'(1))
        else $error("entry count jumped");

endmodule

bind sorted_batch_fnv_fold_hash sbf_checker u_sbf_checker (.*);
